>>> hdl/bpa_pkg.sv
// shared types and constants of the bitmap page allocator
// no dependencies; used by bitmap_page_allocator

package bpa_pkg;

   localparam int WORD_BITS  = 32;   // pages per bitmap word
   localparam int CHUNK_BITS = 8;    // pages examined per scan cycle
   localparam int LEN_W      = 11;
   localparam int ADDR_W     = 32;
   localparam int STAT_W     = 2;

   localparam int DEF_PAGES      = 1024;
   localparam int DEF_PAGE_SHIFT = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_RUN    = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_BUSY  = 2'd3;

   typedef struct packed {
      logic              opcode;
      logic [LEN_W-1:0]  run_length;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic [STAT_W-1:0] status;
   } rsp_type;

endpackage

>>> hdl/bitmap_page_allocator.sv
// first-fit page frame allocator over a busy bitmap held in one memory
// depends on bpa_pkg
//
//   port group  dir   handshake            carries
//   req_*       in    req_valid/req_stall  bpa_pkg::req_type (opcode, run_length, free_address)
//   rsp_*       out   rsp_valid/rsp_stall  bpa_pkg::rsp_type (result_address, status)
//   csr_*       in    csr_we               area_start, 32 bits
//
// after reset a clearing pass writes every bitmap word to zero, and no item is
// taken until it is done
// alloc: a first-fit scan, then a pass that sets the bits of the run word by word;
// the scan looks at 8 pages a cycle out of one registered memory word
// free: a check pass then a clear pass, one word a cycle
// one item at a time; the next item is taken while the last result waits on rsp_stall
// PAGES is expected to be a multiple of 32

module bitmap_page_allocator #(
   parameter int PAGES      = bpa_pkg::DEF_PAGES,
   parameter int PAGE_SHIFT = bpa_pkg::DEF_PAGE_SHIFT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bpa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bpa_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [bpa_pkg::ADDR_W-1:0]    csr_wdata
);

   localparam int MAP_WORDS = PAGES / bpa_pkg::WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(bpa_pkg::WORD_BITS);
   localparam int PIDX_W    = WORD_AW + BIT_W;
   localparam int CHUNKS    = bpa_pkg::WORD_BITS / bpa_pkg::CHUNK_BITS;
   localparam int CHUNK_W   = $clog2(CHUNKS);
   localparam int POS_W     = $clog2(bpa_pkg::CHUNK_BITS);
   localparam int AW        = bpa_pkg::ADDR_W;
   localparam int LW        = bpa_pkg::LEN_W;

   localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(MAP_WORDS - 1);
   localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNKS - 1);
   localparam logic [AW-1:0]      LOW_MASK   = AW'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [AW:0]        PAGES_X    = (AW + 1)'(PAGES);

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_DECODE   = 9'b000000100,
      S_RANGE    = 9'b000001000,
      S_SCAN     = 9'b000010000,
      S_RD_FIRST = 9'b000100000,
      S_CHECK    = 9'b001000000,
      S_MODIFY   = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

   // bitmap memory, one busy bit per page
   logic [bpa_pkg::WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [bpa_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                          rd_en;
   logic [WORD_AW-1:0]            rd_addr;
   logic                          wr_en;
   logic [WORD_AW-1:0]            wr_addr;
   logic [bpa_pkg::WORD_BITS-1:0] wr_data;

   state_type                  state_ff, state_in;
   bpa_pkg::req_type           req_ff, req_in;
   logic [AW-1:0]              area_start_ff, area_start_in;
   logic [WORD_AW-1:0]         word_ff, word_in;
   logic [CHUNK_W-1:0]         chunk_ff, chunk_in;
   logic [LW-1:0]              run_ff, run_in;
   logic [PIDX_W-1:0]          lo_ff, lo_in;
   logic [PIDX_W-1:0]          hi_ff, hi_in;
   logic [AW-1:0]              off_ff, off_in;
   logic                       set_ff, set_in;
   logic                       chk_ff, chk_in;
   logic [bpa_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bpa_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // scan of one chunk
   logic [bpa_pkg::WORD_BITS-1:0]  shifted_word;
   logic [bpa_pkg::CHUNK_BITS-1:0] chunk_bits;
   logic [LW-1:0]                  run_v;
   logic                           hit;
   logic [POS_W-1:0]               hit_pos;
   logic [PIDX_W-1:0]              end_page;
   logic [PIDX_W-1:0]              start_page;
   logic [LW-1:0]                  len_m1;

   // run mask within the current word
   logic [WORD_AW-1:0]            lo_word, hi_word;
   logic [BIT_W-1:0]              lb, ub;
   logic [bpa_pkg::WORD_BITS-1:0] run_mask;

   // free range checks
   logic [AW-1:0] idx;
   logic [AW:0]   idx_end;
   logic          bad_range;

   logic out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   // first-fit search over the current chunk, counting the free run across chunks
   always_comb begin
      shifted_word = rd_data_ff >> {chunk_ff, {POS_W{1'b0}}};
      chunk_bits   = shifted_word[bpa_pkg::CHUNK_BITS-1:0];
      run_v        = run_ff;
      hit          = 1'b0;
      hit_pos      = '0;
      for (int k = 0; k < bpa_pkg::CHUNK_BITS; k++) begin
         if (!hit) begin
            if (chunk_bits[k]) begin
               run_v = '0;
            end else begin
               run_v = run_v + LW'(1);
            end
            if (run_v == req_ff.run_length) begin
               hit     = 1'b1;
               hit_pos = POS_W'(k);
            end
         end
      end
      len_m1     = req_ff.run_length - LW'(1);
      end_page   = {word_ff, chunk_ff, hit_pos};
      start_page = end_page - PIDX_W'(len_m1);
   end

   always_comb begin
      lo_word  = lo_ff[PIDX_W-1:BIT_W];
      hi_word  = hi_ff[PIDX_W-1:BIT_W];
      lb       = (word_ff == lo_word) ? lo_ff[BIT_W-1:0] : '0;
      ub       = (word_ff == hi_word) ? hi_ff[BIT_W-1:0] : '1;
      run_mask = ({bpa_pkg::WORD_BITS{1'b1}} << lb) & ({bpa_pkg::WORD_BITS{1'b1}} >> (~ub));
   end

   always_comb begin
      idx       = off_ff >> PAGE_SHIFT;
      idx_end   = {1'b0, idx} + (AW + 1)'(req_ff.run_length);
      bad_range = ((off_ff & LOW_MASK) != '0) || ({1'b0, idx} >= PAGES_X) ||
                  (idx_end > PAGES_X);
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      area_start_in = area_start_ff;
      word_in       = word_ff;
      chunk_in      = chunk_ff;
      run_in        = run_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      off_in        = off_ff;
      set_in        = set_ff;
      chk_in        = chk_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = '0;

      if (csr_we) begin
         area_start_in = csr_wdata;
      end
      // result taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // zero one bitmap word a cycle
            wr_en   = 1'b1;
            wr_data = '0;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WORD_AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (req_ff.opcode == bpa_pkg::OP_FREE) begin
               off_in   = req_ff.free_address - area_start_ff;
               state_in = S_RANGE;
            end else if (req_ff.run_length == '0) begin
               lo_in    = '0;
               stat_in  = bpa_pkg::ST_OK;
               state_in = S_RESP;
            end else if (32'(req_ff.run_length) > 32'(PAGES)) begin
               stat_in  = bpa_pkg::ST_NO_RUN;
               state_in = S_RESP;
            end else begin
               // start the scan at word zero
               rd_en    = 1'b1;
               rd_addr  = '0;
               word_in  = '0;
               chunk_in = '0;
               run_in   = '0;
               set_in   = 1'b1;
               chk_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_RANGE: begin
            if (bad_range) begin
               stat_in  = bpa_pkg::ST_BAD_RANGE;
               state_in = S_RESP;
            end else if (req_ff.run_length == '0) begin
               stat_in  = bpa_pkg::ST_OK;
               state_in = S_RESP;
            end else begin
               lo_in    = idx[PIDX_W-1:0];
               hi_in    = PIDX_W'(idx_end - (AW + 1)'(1));
               set_in   = 1'b0;
               chk_in   = 1'b1;
               state_in = S_RD_FIRST;
            end
         end
         S_SCAN: begin
            if (hit) begin
               lo_in    = start_page;
               hi_in    = end_page;
               state_in = S_RD_FIRST;
            end else if (chunk_ff == LAST_CHUNK) begin
               if (word_ff == LAST_WORD) begin
                  stat_in  = bpa_pkg::ST_NO_RUN;
                  state_in = S_RESP;
               end else begin
                  // next word arrives as this one is used up
                  rd_en    = 1'b1;
                  rd_addr  = word_ff + WORD_AW'(1);
                  word_in  = word_ff + WORD_AW'(1);
                  chunk_in = '0;
                  run_in   = run_v;
               end
            end else begin
               chunk_in = chunk_ff + CHUNK_W'(1);
               run_in   = run_v;
            end
         end
         S_RD_FIRST: begin
            rd_en    = 1'b1;
            rd_addr  = lo_word;
            word_in  = lo_word;
            state_in = chk_ff ? S_CHECK : S_MODIFY;
         end
         S_CHECK: begin
            // every page of the run must be busy before any is cleared
            if ((rd_data_ff & run_mask) != run_mask) begin
               stat_in  = bpa_pkg::ST_NOT_BUSY;
               state_in = S_RESP;
            end else if (word_ff == hi_word) begin
               chk_in   = 1'b0;
               state_in = S_RD_FIRST;
            end else begin
               rd_en   = 1'b1;
               rd_addr = word_ff + WORD_AW'(1);
               word_in = word_ff + WORD_AW'(1);
            end
         end
         S_MODIFY: begin
            // write back this word while the next one is read
            wr_en   = 1'b1;
            wr_addr = word_ff;
            wr_data = set_ff ? (rd_data_ff | run_mask) : (rd_data_ff & ~run_mask);
            if (word_ff == hi_word) begin
               stat_in  = bpa_pkg::ST_OK;
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = word_ff + WORD_AW'(1);
               word_in = word_ff + WORD_AW'(1);
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = stat_ff;
               if (req_ff.opcode == bpa_pkg::OP_ALLOC && stat_ff == bpa_pkg::ST_OK) begin
                  rsp_data_in.result_address = area_start_ff + (AW'(lo_ff) << PAGE_SHIFT);
               end else begin
                  rsp_data_in.result_address = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         word_ff       <= '0;
         area_start_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         area_start_ff <= area_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      chunk_ff    <= chunk_in;
      run_ff      <= run_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      off_ff      <= off_in;
      set_ff      <= set_in;
      chk_ff      <= chk_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> dv/tb_bitmap_page_allocator.sv
// self-checking testbench for bitmap_page_allocator: directed table, then random runs
// depends on bpa_pkg and bitmap_page_allocator from hdl

module tb_bitmap_page_allocator;

   localparam int PAGES       = bpa_pkg::DEF_PAGES;
   localparam int PAGE_SHIFT  = bpa_pkg::DEF_PAGE_SHIFT;
   localparam int AW          = bpa_pkg::ADDR_W;
   localparam int LW          = bpa_pkg::LEN_W;
   localparam int SW          = bpa_pkg::STAT_W;
   localparam int N_DIRECTED  = 24;
   localparam int SEGMENTS    = 6;
   localparam int SEG_ITEMS   = 290;
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake before giving up
   localparam int TAIL_CYCLES = 200;    // idle wait after the last result is back

   typedef struct packed {
      logic          op;
      logic [LW-1:0] len;
      logic [AW-1:0] addr;
      logic          typed;        // expected result written in the row
      logic [AW-1:0] exp_addr;
      logic [SW-1:0] exp_status;
   } directed_row_type;

   typedef struct {
      int base;
      int len;
   } page_run_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bpa_pkg::req_type  req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bpa_pkg::rsp_type  rsp_data;
   logic              csr_we    = 1'b0;
   logic [AW-1:0]     csr_wdata = '0;

   // shadow copy of the busy bitmap and the area base
   bit                page_busy [PAGES];
   logic [AW-1:0]     area_base = '0;

   bpa_pkg::rsp_type results_due [$];   // one per accepted item, oldest first
   page_run_type     live_runs [$];     // runs known to be allocated, used to build frees

   int error_count  = 0;
   int results_seen = 0;
   int hold_left    = 0;
   int idle_cycles  = 0;
   int send_pct     = 0;
   int recv_pct     = 0;

   bitmap_page_allocator #(
      .PAGES      (PAGES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected result of one request; updates the shadow bitmap
   function automatic bpa_pkg::rsp_type page_request_result(bpa_pkg::req_type r);
      bpa_pkg::rsp_type res;
      int               len;
      int               run;
      int               base;
      int               idx;
      bit               found;
      bit               all_busy;
      logic [AW-1:0]    off;
      logic [AW-1:0]    idx_w;
      res.result_address = '0;
      res.status         = bpa_pkg::ST_OK;
      len = int'(r.run_length);
      if (r.opcode == bpa_pkg::OP_ALLOC) begin
         if (len == 0) begin
            // zero length hands back page 0 and touches nothing
            res.result_address = area_base;
         end else if (len > PAGES) begin
            res.status = bpa_pkg::ST_NO_RUN;
         end else begin
            // first fit: the first place where the free streak reaches len
            run   = 0;
            base  = 0;
            found = 1'b0;
            for (int i = 0; i < PAGES && !found; i++) begin
               run = page_busy[i] ? 0 : run + 1;
               if (run == len) begin
                  found = 1'b1;
                  base  = i - len + 1;
               end
            end
            if (found) begin
               for (int j = 0; j < len; j++) page_busy[base + j] = 1'b1;
               res.result_address = area_base + (AW'(base) << PAGE_SHIFT);
            end else begin
               res.status = bpa_pkg::ST_NO_RUN;
            end
         end
      end else begin
         // offset wraps modulo 2^32, then must be page aligned and in range
         off   = r.free_address - area_base;
         idx_w = off >> PAGE_SHIFT;
         if ((off & ((AW'(1) << PAGE_SHIFT) - AW'(1))) != '0 ||
             idx_w >= AW'(PAGES) || 64'(idx_w) + 64'(len) > 64'(PAGES)) begin
            res.status = bpa_pkg::ST_BAD_RANGE;
         end else begin
            idx      = int'(idx_w);
            all_busy = 1'b1;
            for (int j = 0; j < len; j++) if (!page_busy[idx + j]) all_busy = 1'b0;
            // a run with any free page is refused whole
            if (!all_busy) begin
               res.status = bpa_pkg::ST_NOT_BUSY;
            end else begin
               for (int j = 0; j < len; j++) page_busy[idx + j] = 1'b0;
            end
         end
      end
      return res;
   endfunction

   function automatic int draw_run_length();
      int p;
      p = $urandom_range(99);
      if (p < 3) return 0;
      if (p < 70) return $urandom_range(8, 1);
      if (p < 90) return $urandom_range(64, 9);
      if (p < 97) return $urandom_range(PAGES, 65);
      return $urandom_range(2047, PAGES + 1);
   endfunction

   // offer one item, with random sender gaps, and queue its result on acceptance
   task automatic send_item(input bpa_pkg::req_type item, input logic typed,
                            input bpa_pkg::rsp_type typed_rsp,
                            output bpa_pkg::rsp_type predicted);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = page_request_result(item);
      results_due.push_back(typed ? typed_rsp : predicted);
   endtask

   // stop offering and wait until every queued result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_area(input logic [AW-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      area_base = value;
   endtask

   // result side: check against the oldest expectation, drive stall
   always @(posedge clock) begin : result_check
      bpa_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result addr %h status %0d", $time,
                        rsp_data.result_address, rsp_data.status);
               error_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_data.result_address !== want.result_address) begin
                  $display("%0t: result_address expected %h actual %h", $time,
                           want.result_address, rsp_data.result_address);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
                  error_count++;
               end
            end
            // two long hold-offs so the block backs up into its input
            if (results_seen == 150 || results_seen == 1600) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_pct);
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type dir_rows [N_DIRECTED];
      logic [AW-1:0]    seg_area [SEGMENTS];
      bpa_pkg::req_type item;
      bpa_pkg::rsp_type typed_rsp;
      bpa_pkg::rsp_type predicted;
      page_run_type     run_e;
      page_run_type     last_freed;
      int               pick;
      int               j;
      int               k;

      // rows with typed results assume area_start 0 and start from an empty map
      dir_rows = '{
         '{bpa_pkg::OP_ALLOC, 11'd0, 32'hFFFF_FFFF, 1'b1, 32'h0, bpa_pkg::ST_OK}, // zero length
         '{bpa_pkg::OP_ALLOC, 11'd1, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_ALLOC, 11'd1025, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_NO_RUN}, // over count
         '{bpa_pkg::OP_ALLOC, 11'd2047, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_NO_RUN},
         '{bpa_pkg::OP_FREE, 11'd1, 32'h0000_0001, 1'b1, 32'h0,
           bpa_pkg::ST_BAD_RANGE},                                              // misaligned
         '{bpa_pkg::OP_FREE, 11'd1, 32'h0040_0000, 1'b1, 32'h0,
           bpa_pkg::ST_BAD_RANGE},                                              // index past end
         '{bpa_pkg::OP_FREE, 11'd2, 32'h003F_F000, 1'b1, 32'h0,
           bpa_pkg::ST_BAD_RANGE},                                              // run past end
         '{bpa_pkg::OP_FREE, 11'd2047, 32'hFFFF_FFFF, 1'b1, 32'h0, bpa_pkg::ST_BAD_RANGE},
         '{bpa_pkg::OP_FREE, 11'd1, 32'h0000_1000, 1'b1, 32'h0,
           bpa_pkg::ST_NOT_BUSY},                                               // already free
         '{bpa_pkg::OP_FREE, 11'd0, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_OK},      // zero length free
         '{bpa_pkg::OP_FREE, 11'd1, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_ALLOC, 11'd1024, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_OK},  // whole map
         '{bpa_pkg::OP_ALLOC, 11'd1, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_NO_RUN}, // map full
         '{bpa_pkg::OP_FREE, 11'd1, 32'h003F_F000, 1'b1, 32'h0, bpa_pkg::ST_OK}, // last page
         '{bpa_pkg::OP_ALLOC, 11'd2, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_NO_RUN},
         '{bpa_pkg::OP_ALLOC, 11'd1, 32'h0, 1'b1, 32'h003F_F000, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_FREE, 11'd1024, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_FREE, 11'd1, 32'h0, 1'b1, 32'h0, bpa_pkg::ST_NOT_BUSY},
         '{bpa_pkg::OP_ALLOC, 11'd3, 32'h0, 1'b0, 32'h0, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_ALLOC, 11'd5, 32'h0, 1'b0, 32'h0, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_FREE, 11'd1, 32'h0000_1000, 1'b0, 32'h0, bpa_pkg::ST_OK}, // punch a hole
         '{bpa_pkg::OP_ALLOC, 11'd1, 32'h0, 1'b0, 32'h0, bpa_pkg::ST_OK},        // refills it
         '{bpa_pkg::OP_FREE, 11'd8, 32'h0, 1'b0, 32'h0, bpa_pkg::ST_OK},
         '{bpa_pkg::OP_FREE, 11'd0, 32'h003F_F000, 1'b1, 32'h0, bpa_pkg::ST_OK}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_area('0);

      send_pct = 28;
      recv_pct = 62;
      for (int r = 0; r < N_DIRECTED; r++) begin
         item.opcode          = dir_rows[r].op;
         item.run_length      = dir_rows[r].len;
         item.free_address    = dir_rows[r].addr;
         typed_rsp.result_address = dir_rows[r].exp_addr;
         typed_rsp.status         = dir_rows[r].exp_status;
         send_item(item, dir_rows[r].typed, typed_rsp, predicted);
      end

      // area settings per segment, including both ends and a wrapping base
      seg_area = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_F000,
                   $urandom & 32'hFFFF_F000, 32'h8000_0000};
      last_freed = '{base: 0, len: 1};

      for (int s = 0; s < SEGMENTS; s++) begin
         // drains first, so each new base lands on an idle block
         set_area(seg_area[s]);
         case (s / 2)
            0: begin
               send_pct = 28;
               recv_pct = 62;
            end
            1: begin
               send_pct = 62;
               recv_pct = 28;
            end
            default: begin
               send_pct = 0;
               recv_pct = 0;
            end
         endcase
         for (int n = 0; n < SEG_ITEMS; n++) begin
            pick              = $urandom_range(99);
            item.opcode       = bpa_pkg::OP_ALLOC;
            item.free_address = $urandom;
            item.run_length   = LW'(draw_run_length());
            if (pick < 45 || live_runs.size() == 0) begin
               // allocate with the drawn length
            end else if (pick < 80) begin
               // free a known run, sometimes only its leading part
               j     = $urandom_range(live_runs.size() - 1);
               run_e = live_runs[j];
               live_runs.delete(j);
               k = run_e.len;
               if (run_e.len > 1 && $urandom_range(3) == 0) begin
                  k = $urandom_range(run_e.len - 1, 1);
                  live_runs.push_back('{base: run_e.base + k, len: run_e.len - k});
               end
               item.opcode       = bpa_pkg::OP_FREE;
               item.run_length   = LW'(k);
               item.free_address = area_base + (AW'(run_e.base) << PAGE_SHIFT);
               last_freed        = '{base: run_e.base, len: k};
            end else if (pick < 86) begin
               // double free of the last run given back
               item.opcode       = bpa_pkg::OP_FREE;
               item.run_length   = LW'(last_freed.len);
               item.free_address = area_base + (AW'(last_freed.base) << PAGE_SHIFT);
            end else if (pick < 93) begin
               // near-valid free: edge indices, odd offsets
               item.opcode       = bpa_pkg::OP_FREE;
               item.free_address = area_base
                  + (AW'($urandom_range(PAGES + 4)) << PAGE_SHIFT)
                  + ($urandom_range(1) ? AW'($urandom_range((1 << PAGE_SHIFT) - 1))
                                       : AW'(0));
            end else begin
               // raw noise on every field
               item.opcode     = 1'($urandom_range(1));
               item.run_length = LW'($urandom_range(2047));
            end
            send_item(item, 1'b0, typed_rsp, predicted);
            if (item.opcode == bpa_pkg::OP_ALLOC && predicted.status == bpa_pkg::ST_OK &&
                item.run_length != 0)
               live_runs.push_back('{
                  base: int'((predicted.result_address - area_base) >> PAGE_SHIFT),
                  len:  int'(item.run_length)});
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> bitmap_page_allocator.f
hdl/bpa_pkg.sv
hdl/bitmap_page_allocator.sv
dv/tb_bitmap_page_allocator.sv
